// ===== rtl/cholesky_decompose_3x3_assert.svh =====
// assertion macros for the cholesky_decompose_3x3 rtl
`ifndef CHOLESKY_DECOMPOSE_3X3_ASSERT_SVH
`define CHOLESKY_DECOMPOSE_3X3_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is high
`define CHOL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cholesky_decompose_3x3: assertion failed");

// clocked check that also holds across reset
`define CHOL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cholesky_decompose_3x3: assertion failed");

`else

`define CHOL_ASSERT(label, clk, rst, prop)
`define CHOL_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/chol_pkg.sv =====
package chol_pkg;

  // quotient bits kept by the dividers, also the off-diagonal width
  localparam int QW = 32;
  // width of the unsigned diagonal outputs
  localparam int DIAG_W = 31;
  // stream data width on both sides
  localparam int TDATA_W = 192;

  // magnitude of a 32-bit two's complement value
  function automatic logic [QW-1:0] mag32(input logic [QW-1:0] x);
    mag32 = x[QW-1] ? (~x + 1'b1) : x;
  endfunction

  // clamp a sign and magnitude quotient to the signed 32-bit range
  function automatic logic [QW-1:0] sat32(input logic neg, input logic ovf,
                                          input logic [QW-1:0] q);
    logic big;
    big = ovf | q[QW-1];
    if (!neg) begin
      sat32 = big ? {1'b0, {(QW-1){1'b1}}} : q;
    end else begin
      sat32 = big ? {1'b1, {(QW-1){1'b0}}} : (~q + 1'b1);
    end
  endfunction

endpackage

// ===== rtl/chol_sqrt.sv =====
module chol_sqrt
  import chol_pkg::*;
#(
  parameter int W  = 48,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     in_rad,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [W/2-1:0]   out_root,
  output logic [SW-1:0]    out_side
);

  localparam int R   = W / 2;
  localparam int RMW = R + 2;

  logic          vld  [0:R-1];
  logic [RMW-1:0] rem [0:R-1];
  logic [R-1:0]  root [0:R-1];
  logic [W-1:0]  rad  [0:R-1];
  logic [SW-1:0] side [0:R-1];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar i = 0; i < R; i++) begin : g_stage
    logic           v_i;
    logic [RMW-1:0] rem_i;
    logic [R-1:0]   root_i;
    logic [W-1:0]   rad_i;
    logic [SW-1:0]  side_i;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld[i-1];
      assign rem_i  = rem[i-1];
      assign root_i = root[i-1];
      assign rad_i  = rad[i-1];
      assign side_i = side[i-1];
    end

    assign cur   = {rem_i[RMW-3:0], rad_i[W-1 -: 2]};
    assign trial = {root_i, 2'b01};

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_i;
      end
    end

    // trial subtract
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem[i]  <= cur - trial;
          root[i] <= {root_i[R-2:0], 1'b1};
        end else begin
          rem[i]  <= cur;
          root[i] <= {root_i[R-2:0], 1'b0};
        end
        rad[i]  <= {rad_i[W-3:0], 2'b00};
        side[i] <= side_i;
      end
    end
  end

  assign out_valid = vld[R-1];
  assign out_root  = root[R-1];
  assign out_side  = side[R-1];

endmodule

// ===== rtl/chol_div.sv =====
module chol_div
  import chol_pkg::*;
#(
  parameter int NW = 32,
  parameter int SH = 16,
  parameter int DW = 24,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_mag,
  input  logic           in_neg,
  input  logic [DW-1:0]  in_den,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [QW-1:0]  out_q,
  output logic [SW-1:0]  out_side
);

  localparam int NT = NW + SH;
  localparam int HW = NT - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic          vld  [0:QW-1];
  logic [DW-1:0] rem  [0:QW-1];
  logic [DW-1:0] den  [0:QW-1];
  logic [QW-1:0] quo  [0:QW-1];
  logic [QW-1:0] lo   [0:QW-1];
  logic          ovf  [0:QW-1];
  logic          neg  [0:QW-1];
  logic [SW-1:0] side [0:QW-1];

  // scaled numerator split into the part above the quotient and the rest
  logic [NT-1:0] num;
  logic [HW-1:0] hi0;
  logic          ovf0;
  logic [DW-1:0] rem0;

  assign num  = {in_mag, {SH{1'b0}}};
  assign hi0  = num[NT-1:QW];
  assign ovf0 = CW'(hi0) >= CW'(in_den);
  assign rem0 = ovf0 ? '0 : DW'(hi0);

  // one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] quo_i;
    logic [QW-1:0] lo_i;
    logic          ovf_i;
    logic          neg_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   cur;
    logic [DW:0]   dif;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = rem0;
      assign den_i  = in_den;
      assign quo_i  = '0;
      assign lo_i   = num[QW-1:0];
      assign ovf_i  = ovf0;
      assign neg_i  = in_neg;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld[i-1];
      assign rem_i  = rem[i-1];
      assign den_i  = den[i-1];
      assign quo_i  = quo[i-1];
      assign lo_i   = lo[i-1];
      assign ovf_i  = ovf[i-1];
      assign neg_i  = neg[i-1];
      assign side_i = side[i-1];
    end

    assign cur = {rem_i, lo_i[QW-1]};
    assign dif = cur - {1'b0, den_i};

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_i;
      end
    end

    // restoring step
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= {1'b0, den_i}) begin
          rem[i] <= dif[DW-1:0];
          quo[i] <= {quo_i[QW-2:0], 1'b1};
        end else begin
          rem[i] <= cur[DW-1:0];
          quo[i] <= {quo_i[QW-2:0], 1'b0};
        end
        den[i]  <= den_i;
        lo[i]   <= {lo_i[QW-2:0], 1'b0};
        ovf[i]  <= ovf_i;
        neg[i]  <= neg_i;
        side[i] <= side_i;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_q     = sat32(neg[QW-1], ovf[QW-1], quo[QW-1]);
  assign out_side  = side[QW-1];

endmodule

// ===== rtl/cholesky_decompose_3x3.sv =====
// Cholesky factor of a symmetric 3x3 matrix, signed fixed point, fully pipelined.
// Input stream s_axis: one beat is one matrix, six 32-bit entries a00, a01, a02,
// a11, a12, a22 with FRAC_BITS fraction bits. Output stream m_axis: one beat per
// input beat, in order, with the six lower-triangle factor entries and a
// not-positive-definite flag in tuser; when the flag is set all factor entries are 0.
// Throughput: one beat per cycle while s_axis_tready is high. Each beat passes through
// three square-root pipelines of R stages, R = ceil((31 + FRAC_BITS) / 2), two
// divider pipelines of 32 stages in turn, two multiply/subtract stage pairs and
// the output register.
// All stages advance together; a two-entry output buffer (output register plus
// skid register) lets the pipeline keep taking beats while one result waits.
// When the receiver stalls and the skid register fills, s_axis_tready drops and
// the whole pipeline holds; nothing is lost or repeated.
// Reset (rst, synchronous) empties every stage; beats in flight are dropped.
module cholesky_decompose_3x3
  import chol_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // a00, a01, a02, a11, a12, a22 (32 bits each)
  input  logic [TDATA_W-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // f00 (31), f10 (32), f11 (31), f20 (32), f21 (32), f22 (31), 3 zero bits
  output logic [TDATA_W-1:0] m_axis_tdata,
  // not_definite
  output logic [0:0]         m_axis_tuser
);

  `include "cholesky_decompose_3x3_assert.svh"

  localparam int RADN = 31 + FRAC_BITS;
  localparam int RADW = RADN + (RADN % 2);
  localparam int RW   = RADW / 2;
  localparam int NW2  = 63 - FRAC_BITS;
  localparam int PW   = 2 * QW;

  localparam int S0W = 5 * QW + 1;
  localparam int S1W = RW + 2 * QW + 1;
  localparam int S3W = RW + 2 * QW + 2 * PW + 1;
  localparam int S4W = 2 * RW + 2 * QW + PW + 1;
  localparam int S5W = 2 * RW + 3 * QW + 1;

  logic en;
  logic skid_v;

  assign en            = !skid_v;
  assign s_axis_tready = en;

  // ---------------- first pivot ----------------
  logic [QW-1:0]   a00, a01, a02, a11, a12, a22;
  logic            nd0;
  logic [RADW-1:0] rad0;

  assign a00  = s_axis_tdata[0*QW +: QW];
  assign a01  = s_axis_tdata[1*QW +: QW];
  assign a02  = s_axis_tdata[2*QW +: QW];
  assign a11  = s_axis_tdata[3*QW +: QW];
  assign a12  = s_axis_tdata[4*QW +: QW];
  assign a22  = s_axis_tdata[5*QW +: QW];
  assign nd0  = a00[QW-1] | (a00 == '0);
  assign rad0 = RADW'({a00[QW-2:0], {FRAC_BITS{1'b0}}});

  logic           vs0;
  logic [RW-1:0]  d0_s;
  logic [S0W-1:0] side0;

  chol_sqrt #(.W(RADW), .SW(S0W)) u_sqrt0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_rad    (rad0),
    .in_side   ({a01, a02, a11, a12, a22, nd0}),
    .out_valid (vs0),
    .out_root  (d0_s),
    .out_side  (side0)
  );

  logic [QW-1:0] a01_s, a02_s, a11_s, a12_s, a22_s;
  logic          nd_s;

  assign {a01_s, a02_s, a11_s, a12_s, a22_s, nd_s} = side0;

  // ---------------- first column divisions ----------------
  logic           v10, v20;
  logic [QW-1:0]  l10_q, l20_q;
  logic [S1W-1:0] side10;
  logic [QW-1:0]  a22_q;

  chol_div #(.NW(QW), .SH(FRAC_BITS), .DW(RW), .SW(S1W)) u_div10 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vs0),
    .in_mag    (mag32(a01_s)),
    .in_neg    (a01_s[QW-1]),
    .in_den    (d0_s),
    .in_side   ({d0_s, a11_s, a12_s, nd_s}),
    .out_valid (v10),
    .out_q     (l10_q),
    .out_side  (side10)
  );

  chol_div #(.NW(QW), .SH(FRAC_BITS), .DW(RW), .SW(QW)) u_div20 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vs0),
    .in_mag    (mag32(a02_s)),
    .in_neg    (a02_s[QW-1]),
    .in_den    (d0_s),
    .in_side   (a22_s),
    .out_valid (v20),
    .out_q     (l20_q),
    .out_side  (a22_q)
  );

  logic [RW-1:0] d0_q;
  logic [QW-1:0] a11_q, a12_q;
  logic          nd_q;

  assign {d0_q, a11_q, a12_q, nd_q} = side10;

  // ---------------- stage a: products of the first column ----------------
  logic          va;
  logic [PW-1:0] pa1, pa2, pa3;
  logic          sgn2_a;
  logic [RW-1:0] d0_a;
  logic [QW-1:0] l10_a, l20_a, a11_a, a12_a, a22_a;
  logic          nd_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1    <= PW'(mag32(l10_q)) * PW'(mag32(l10_q));
      pa2    <= PW'(mag32(l20_q)) * PW'(mag32(l10_q));
      pa3    <= PW'(mag32(l20_q)) * PW'(mag32(l20_q));
      sgn2_a <= l20_q[QW-1] ^ l10_q[QW-1];
      d0_a   <= d0_q;
      l10_a  <= l10_q;
      l20_a  <= l20_q;
      a11_a  <= a11_q;
      a12_a  <= a12_q;
      a22_a  <= a22_q;
      nd_a   <= nd_q;
    end
  end

  // ---------------- stage b: second pivot and partial sums ----------------
  logic [PW-1:0] q1, q2, q3, mq2;
  logic [PW-1:0] p1_n, n21_n, p2a_n;

  assign q1    = pa1 >> FRAC_BITS;
  assign q2    = pa2 >> FRAC_BITS;
  assign q3    = pa3 >> FRAC_BITS;
  assign mq2   = sgn2_a ? (~q2 + 1'b1) : q2;
  assign p1_n  = {{QW{a11_a[QW-1]}}, a11_a} - q1;
  assign n21_n = {{QW{a12_a[QW-1]}}, a12_a} - mq2;
  assign p2a_n = {{QW{a22_a[QW-1]}}, a22_a} - q3;

  logic          vb;
  logic [PW-1:0] p1_b, n21_b, p2a_b;
  logic [RW-1:0] d0_b;
  logic [QW-1:0] l10_b, l20_b;
  logic          nd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_b  <= p1_n;
      n21_b <= n21_n;
      p2a_b <= p2a_n;
      d0_b  <= d0_a;
      l10_b <= l10_a;
      l20_b <= l20_a;
      nd_b  <= nd_a | p1_n[PW-1] | (p1_n == '0);
    end
  end

  // ---------------- second pivot root ----------------
  logic           vs1;
  logic [RW-1:0]  d1_s;
  logic [S3W-1:0] side1;

  chol_sqrt #(.W(RADW), .SW(S3W)) u_sqrt1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .in_rad    (RADW'({p1_b[QW-2:0], {FRAC_BITS{1'b0}}})),
    .in_side   ({d0_b, l10_b, l20_b, n21_b, p2a_b, nd_b}),
    .out_valid (vs1),
    .out_root  (d1_s),
    .out_side  (side1)
  );

  logic [RW-1:0] d0_1;
  logic [QW-1:0] l10_1, l20_1;
  logic [PW-1:0] n21_1, p2a_1, n21_m;
  logic          nd_1;

  assign {d0_1, l10_1, l20_1, n21_1, p2a_1, nd_1} = side1;
  assign n21_m = n21_1[PW-1] ? (~n21_1 + 1'b1) : n21_1;

  // ---------------- second column division ----------------
  logic           v21;
  logic [QW-1:0]  l21_q;
  logic [S4W-1:0] side21;

  chol_div #(.NW(NW2), .SH(FRAC_BITS), .DW(RW), .SW(S4W)) u_div21 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vs1),
    .in_mag    (n21_m[NW2-1:0]),
    .in_neg    (n21_1[PW-1]),
    .in_den    (d1_s),
    .in_side   ({d0_1, d1_s, l10_1, l20_1, p2a_1, nd_1}),
    .out_valid (v21),
    .out_q     (l21_q),
    .out_side  (side21)
  );

  logic [RW-1:0] d0_2, d1_2;
  logic [QW-1:0] l10_2, l20_2;
  logic [PW-1:0] p2a_2;
  logic          nd_2;

  assign {d0_2, d1_2, l10_2, l20_2, p2a_2, nd_2} = side21;

  // ---------------- stage c: square of the last off-diagonal ----------------
  logic          vc;
  logic [PW-1:0] pc4, p2a_c;
  logic [RW-1:0] d0_c, d1_c;
  logic [QW-1:0] l10_c, l20_c, l21_c;
  logic          nd_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= v21;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc4   <= PW'(mag32(l21_q)) * PW'(mag32(l21_q));
      p2a_c <= p2a_2;
      d0_c  <= d0_2;
      d1_c  <= d1_2;
      l10_c <= l10_2;
      l20_c <= l20_2;
      l21_c <= l21_q;
      nd_c  <= nd_2;
    end
  end

  // ---------------- stage d: third pivot ----------------
  logic [PW-1:0] p2_n;

  assign p2_n = p2a_c - (pc4 >> FRAC_BITS);

  logic          vd;
  logic [PW-1:0] p2_d;
  logic [RW-1:0] d0_d, d1_d;
  logic [QW-1:0] l10_d, l20_d, l21_d;
  logic          nd_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_d  <= p2_n;
      d0_d  <= d0_c;
      d1_d  <= d1_c;
      l10_d <= l10_c;
      l20_d <= l20_c;
      l21_d <= l21_c;
      nd_d  <= nd_c | p2_n[PW-1] | (p2_n == '0);
    end
  end

  // ---------------- third pivot root ----------------
  logic           vs2;
  logic [RW-1:0]  d2_s;
  logic [S5W-1:0] side2;

  chol_sqrt #(.W(RADW), .SW(S5W)) u_sqrt2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vd),
    .in_rad    (RADW'({p2_d[QW-2:0], {FRAC_BITS{1'b0}}})),
    .in_side   ({d0_d, d1_d, l10_d, l20_d, l21_d, nd_d}),
    .out_valid (vs2),
    .out_root  (d2_s),
    .out_side  (side2)
  );

  logic [RW-1:0] d0_f, d1_f;
  logic [QW-1:0] l10_f, l20_f, l21_f;
  logic          nd_f;

  assign {d0_f, d1_f, l10_f, l20_f, l21_f, nd_f} = side2;

  // result beat, zeroed when a pivot was not positive
  logic [TDATA_W-1:0] fin;

  assign fin = nd_f ? '0 :
               {3'b000, DIAG_W'(d2_s), l21_f, l20_f, DIAG_W'(d1_f), l10_f, DIAG_W'(d0_f)};

  // ---------------- output register and skid register ----------------
  logic [TDATA_W-1:0] skid_data;
  logic               skid_nd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_v        <= 1'b0;
    end else if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_v) begin
        m_axis_tvalid <= 1'b1;
        skid_v        <= 1'b0;
      end else begin
        m_axis_tvalid <= vs2;
      end
    end else if (!skid_v && vs2) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_v) begin
        m_axis_tdata <= skid_data;
        m_axis_tuser <= skid_nd;
      end else begin
        m_axis_tdata <= fin;
        m_axis_tuser <= nd_f;
      end
    end else if (!skid_v) begin
      skid_data <= fin;
      skid_nd   <= nd_f;
    end
  end

  // ---------------- checks ----------------
  `CHOL_ASSERT(a_div_lanes_aligned, clk, rst, v10 == v20)
  `CHOL_ASSERT(a_flag_zeroes_data, clk, rst, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
  `CHOL_ASSERT(a_diag_nonzero, clk, rst, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[DIAG_W-1:0] != '0)
  `CHOL_ASSERT(a_skid_needs_stall, clk, rst, $rose(skid_v) |-> $past(m_axis_tvalid && !m_axis_tready))
  `CHOL_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !m_axis_tvalid && !skid_v)

endmodule
